### rtl/grid_los_light_map_macros.svh
// Assertion macros for the light map block
`ifndef GRID_LOS_LIGHT_MAP_MACROS_SVH
`define GRID_LOS_LIGHT_MAP_MACROS_SVH
// Check that an antecedent implies a consequent on the next clock edge.
`define GLM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
// Check that an antecedent implies a consequent on the same clock edge.
`define GLM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`endif

### rtl/glm_pkg.sv
// Package of types and constants for the grid light map
package glm_pkg;
   localparam int CMD_W = 3;
   localparam int LEVEL_W = 3;
   localparam int COORD_W = 7;
   localparam int CSR_W = 8;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX = 3'd7;

   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE = 3'd0,
      CMD_CLEAR = 3'd1,
      CMD_FLOOR = 3'd2,
      CMD_WALL  = 3'd3,
      CMD_READ  = 3'd4
   } cmd_type;

   typedef enum logic [0:0] {
      CSR_WIDTH  = 1'b0,
      CSR_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_INIT,
      ST_IDLE,
      ST_RD_WAIT,
      ST_RD_DONE,
      ST_CLEAR,
      ST_F_TILE,
      ST_F_TWAIT,
      ST_F_TCHK,
      ST_F_STEP,
      ST_F_SWAIT,
      ST_F_SCHK,
      ST_F_WRITE,
      ST_W_TILE,
      ST_W_TWAIT,
      ST_W_TCHK,
      ST_W_NB,
      ST_W_NWAIT,
      ST_W_NCHK,
      ST_W_WRITE,
      ST_NEXT,
      ST_RESP
   } state_type;

   // Neighbor offsets, index 0..7
   function automatic logic signed [1:0] nb_dx(input logic [2:0] d);
      case (d)
         3'd0: nb_dx = -2'sd1;
         3'd1: nb_dx = 2'sd1;
         3'd2: nb_dx = 2'sd0;
         3'd3: nb_dx = 2'sd0;
         3'd4: nb_dx = -2'sd1;
         3'd5: nb_dx = -2'sd1;
         default: nb_dx = 2'sd1;
      endcase
   endfunction

   function automatic logic signed [1:0] nb_dy(input logic [2:0] d);
      case (d)
         3'd0: nb_dy = 2'sd0;
         3'd1: nb_dy = 2'sd0;
         3'd2: nb_dy = -2'sd1;
         3'd3: nb_dy = 2'sd1;
         3'd4: nb_dy = -2'sd1;
         3'd5: nb_dy = 2'sd1;
         3'd6: nb_dy = -2'sd1;
         default: nb_dy = 2'sd1;
      endcase
   endfunction
endpackage

### rtl/glm_req_if.sv
// Request and response channel interfaces
interface glm_req_if;
   import glm_pkg::*;
   logic req_valid;
   logic req_ready;
   logic [CMD_W-1:0] req_cmd;
   logic [COORD_W-1:0] req_tile_x;
   logic [COORD_W-1:0] req_tile_y;
   logic req_solid_in;
   modport source (output req_valid, req_cmd, req_tile_x, req_tile_y, req_solid_in,
                   input req_ready);
   modport sink (input req_valid, req_cmd, req_tile_x, req_tile_y, req_solid_in,
                 output req_ready);
endinterface

interface glm_rsp_if;
   import glm_pkg::*;
   logic rsp_valid;
   logic rsp_ready;
   logic [LEVEL_W-1:0] rsp_level;
   logic rsp_solid_out;
   modport source (output rsp_valid, rsp_level, rsp_solid_out, input rsp_ready);
   modport sink (input rsp_valid, rsp_level, rsp_solid_out, output rsp_ready);
endinterface

### rtl/glm_tile_ram.sv
// Tile memory holding solid bit and light level per tile
module glm_tile_ram #(
   parameter int ADDR_W = 14
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic                        wr_solid,
   input  logic [glm_pkg::LEVEL_W-1:0] wr_level,
   input  logic [ADDR_W-1:0]           rd_addr,
   output logic                        rd_solid,
   output logic [glm_pkg::LEVEL_W-1:0] rd_level
);
   import glm_pkg::*;

   logic [LEVEL_W:0] mem_ff [2**ADDR_W];

   // Write one word, read one word, registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= {wr_solid, wr_level};
      end
      {rd_solid, rd_level} <= mem_ff[rd_addr];
   end
endmodule

### rtl/grid_los_light_map.sv
// Top level of the grid line-of-sight light map
//
// Requests come on req (valid/ready) carrying cmd, tile_x, tile_y, solid_in;
// each request yields exactly one response word on rsp (level, solid_out).
// Configuration writes on csr_ (write enable, index, data) set map_width
// (index 0) and map_height (index 1); write only while the block is idle.
// One request is worked at a time; req_ready is low until its response is
// taken. A write tile or read tile reads the tile first. A clear reads and
// writes back every tile. A floor pass visits the (2*RADIUS+1)^2 window
// tiles; each tile is read, then each Bresenham step reads one tile on the
// read port. A wall pass reads each window tile and each neighbor of a dark
// solid tile, which it writes when a lit neighbor is found. All memory
// traffic goes through one tile RAM with one write port and one read port.
// After reset a clearing pass writes every tile solid and dark, one tile a
// cycle, before the first request is taken. A stalled response holds in its
// register until rsp_ready is high.
module grid_los_light_map #(
   parameter int MAX_COLS = 128,
   parameter int MAX_ROWS = 128,
   parameter int RADIUS = 6
) (
   input  logic                      clock,
   input  logic                      reset,
   glm_req_if.sink                   req,
   glm_rsp_if.source                 rsp,
   input  logic                      csr_write,
   input  logic [0:0]                csr_index,
   input  logic [glm_pkg::CSR_W-1:0] csr_data
);
   import glm_pkg::*;
   `include "grid_los_light_map_macros.svh"

   localparam int XW = $clog2(MAX_COLS);
   localparam int YW = $clog2(MAX_ROWS);
   localparam int AW = XW + YW;
   // signed coordinate width, covers -RADIUS-1 .. 1023+RADIUS+1
   localparam int SW = 12;
   localparam int RW = $clog2(RADIUS + 2) + 1;

   state_type state_ff, state_in;
   logic [CSR_W-1:0] width_ff, width_in, height_ff, height_in;
   logic [CMD_W-1:0] cmd_ff, cmd_in;
   logic signed [SW-1:0] px_ff, px_in, py_ff, py_in;
   logic signed [SW-1:0] tx_ff, tx_in, ty_ff, ty_in;
   logic signed [SW-1:0] wx_ff, wx_in, wy_ff, wy_in;
   logic signed [SW-1:0] ax_ff, ax_in, ay_ff, ay_in, err_ff, err_in;
   logic solid_ff, solid_in;
   logic [LEVEL_W-1:0] lvl_ff, lvl_in, best_ff, best_in;
   logic [2:0] nb_ff, nb_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [AW:0] sweep_ff, sweep_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0] rsp_level_ff, rsp_level_in;
   logic rsp_solid_ff, rsp_solid_in;

   logic wr_en, wr_solid;
   logic [LEVEL_W-1:0] wr_level;
   logic [AW-1:0] wr_addr, rd_addr;
   logic rd_solid;
   logic [LEVEL_W-1:0] rd_level;

   glm_tile_ram #(.ADDR_W(AW)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_solid(wr_solid),
      .wr_level(wr_level),
      .rd_addr (rd_addr),
      .rd_solid(rd_solid),
      .rd_level(rd_level)
   );

   // in-map test against clamped size
   function automatic logic in_map(input logic signed [SW-1:0] x,
                                   input logic signed [SW-1:0] y,
                                   input logic [CSR_W-1:0] w,
                                   input logic [CSR_W-1:0] h);
      logic signed [SW-1:0] uw, uh;
      uw = (SW'(w) > SW'(MAX_COLS)) ? SW'(MAX_COLS) : SW'(w);
      uh = (SW'(h) > SW'(MAX_ROWS)) ? SW'(MAX_ROWS) : SW'(h);
      in_map = (x >= 0) && (y >= 0) && (x < uw) && (y < uh);
   endfunction

   function automatic logic [AW-1:0] tile_addr(input logic signed [SW-1:0] x,
                                               input logic signed [SW-1:0] y);
      tile_addr = {y[YW-1:0], x[XW-1:0]};
   endfunction

   function automatic logic signed [SW-1:0] sabs(input logic signed [SW-1:0] v);
      sabs = (v < 0) ? -v : v;
   endfunction

   logic signed [SW-1:0] dxs, dys, adx, ady, cheb_dist, e2, stx, sty, nx, ny;
   logic [RW-1:0] lv_raw;

   always_comb begin
      dxs = tx_ff - px_ff;
      dys = ty_ff - py_ff;
      adx = sabs(dxs);
      ady = sabs(dys);
      cheb_dist = (adx > ady) ? adx : ady;
      lv_raw = RW'(RADIUS + 1) - RW'(cheb_dist);
      e2 = err_ff <<< 1;
      stx = (px_ff < tx_ff) ? SW'(1) : -SW'(1);
      sty = (py_ff < ty_ff) ? SW'(1) : -SW'(1);
      nx = tx_ff + SW'(nb_dx(nb_ff));
      ny = ty_ff + SW'(nb_dy(nb_ff));
   end

   // State register and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         width_ff <= CSR_W'(100);
         height_ff <= CSR_W'(75);
         sweep_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         width_ff <= width_in;
         height_ff <= height_in;
         sweep_ff <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff <= cmd_in;
      px_ff <= px_in;
      py_ff <= py_in;
      tx_ff <= tx_in;
      ty_ff <= ty_in;
      wx_ff <= wx_in;
      wy_ff <= wy_in;
      ax_ff <= ax_in;
      ay_ff <= ay_in;
      err_ff <= err_in;
      solid_ff <= solid_in;
      lvl_ff <= lvl_in;
      best_ff <= best_in;
      nb_ff <= nb_in;
      addr_ff <= addr_in;
      rsp_level_ff <= rsp_level_in;
      rsp_solid_ff <= rsp_solid_in;
   end

   // Sequencer and shared datapath
   always_comb begin
      state_in = state_ff;
      width_in = width_ff;
      height_in = height_ff;
      cmd_in = cmd_ff;
      px_in = px_ff;
      py_in = py_ff;
      tx_in = tx_ff;
      ty_in = ty_ff;
      wx_in = wx_ff;
      wy_in = wy_ff;
      ax_in = ax_ff;
      ay_in = ay_ff;
      err_in = err_ff;
      solid_in = solid_ff;
      lvl_in = lvl_ff;
      best_in = best_ff;
      nb_in = nb_ff;
      addr_in = addr_ff;
      sweep_in = sweep_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_level_in = rsp_level_ff;
      rsp_solid_in = rsp_solid_ff;
      wr_en = 1'b0;
      wr_addr = addr_ff;
      wr_solid = 1'b0;
      wr_level = '0;
      rd_addr = addr_ff;
      req.req_ready = 1'b0;

      if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_WIDTH: width_in = csr_data;
            CSR_HEIGHT: height_in = csr_data;
            default: ;
         endcase
      end
      if (rsp_valid_ff && rsp.rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_INIT, ST_CLEAR: begin
            // sweep memory: init sets solid, clear keeps solid
            addr_in = sweep_ff[AW-1:0];
            rd_addr = sweep_ff[AW-1:0];
            if (state_ff == ST_INIT) begin
               wr_en = 1'b1;
               wr_addr = sweep_ff[AW-1:0];
               wr_solid = 1'b1;
               sweep_in = sweep_ff + 1'b1;
               if (sweep_ff == (AW+1)'(2**AW - 1)) begin
                  state_in = ST_IDLE;
               end
            end else begin
               // read then write back with level zero
               if (sweep_ff[0]) begin
                  wr_en = 1'b1;
                  wr_addr = addr_ff;
                  wr_solid = rd_solid;
               end else begin
                  addr_in = sweep_ff[AW:1];
               end
               rd_addr = sweep_ff[AW:1];
               sweep_in = sweep_ff + 1'b1;
               if (sweep_ff == (AW+1)'(2**(AW+1) - 1)) begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_IDLE: begin
            req.req_ready = !rsp_valid_ff;
            if (req.req_valid && !rsp_valid_ff) begin
               cmd_in = req.req_cmd;
               px_in = SW'(req.req_tile_x);
               py_in = SW'(req.req_tile_y);
               solid_in = req.req_solid_in;
               addr_in = tile_addr(SW'(req.req_tile_x), SW'(req.req_tile_y));
               rsp_level_in = '0;
               rsp_solid_in = 1'b0;
               ty_in = SW'(req.req_tile_y) - SW'(RADIUS);
               tx_in = SW'(req.req_tile_x) - SW'(RADIUS);
               sweep_in = '0;
               case (req.req_cmd)
                  CMD_WRITE: begin
                     if (in_map(SW'(req.req_tile_x), SW'(req.req_tile_y),
                                width_ff, height_ff)) begin
                        state_in = ST_RD_WAIT;
                     end else begin
                        state_in = ST_RESP;
                     end
                  end
                  CMD_READ: begin
                     if (in_map(SW'(req.req_tile_x), SW'(req.req_tile_y),
                                width_ff, height_ff)) begin
                        state_in = ST_RD_WAIT;
                     end else begin
                        state_in = ST_RESP;
                     end
                  end
                  CMD_CLEAR: state_in = ST_CLEAR;
                  CMD_FLOOR: state_in = ST_F_TILE;
                  CMD_WALL: state_in = ST_W_TILE;
                  default: state_in = ST_RESP;
               endcase
            end
         end
         ST_RD_WAIT: state_in = ST_RD_DONE;
         ST_RD_DONE: begin
            if (cmd_ff == CMD_WRITE) begin
               wr_en = 1'b1;
               wr_solid = solid_ff;
               wr_level = rd_level;
            end else begin
               rsp_level_in = rd_level;
               rsp_solid_in = rd_solid;
            end
            state_in = ST_RESP;
         end
         // ---- floor pass ----
         ST_F_TILE: begin
            addr_in = tile_addr(tx_ff, ty_ff);
            rd_addr = tile_addr(tx_ff, ty_ff);
            if (in_map(tx_ff, ty_ff, width_ff, height_ff)) begin
               state_in = ST_F_TWAIT;
            end else begin
               state_in = ST_NEXT;
            end
         end
         ST_F_TWAIT: state_in = ST_F_TCHK;
         ST_F_TCHK: begin
            lvl_in = rd_level;
            ax_in = adx;
            ay_in = ady;
            err_in = adx - ady;
            wx_in = px_ff;
            wy_in = py_ff;
            if (rd_solid) begin
               state_in = ST_NEXT;
            end else if (cheb_dist <= 1) begin
               state_in = ST_F_WRITE;
            end else begin
               state_in = ST_F_STEP;
            end
         end
         ST_F_STEP: begin
            // one Bresenham step
            if (e2 > -ay_ff) begin
               wx_in = wx_ff + stx;
               err_in = err_ff - ay_ff;
            end
            if (e2 < ax_ff) begin
               wy_in = wy_ff + sty;
               err_in = ((e2 > -ay_ff) ? err_ff - ay_ff : err_ff) + ax_ff;
            end
            state_in = ST_F_SWAIT;
         end
         ST_F_SWAIT: begin
            addr_in = tile_addr(wx_ff, wy_ff);
            rd_addr = tile_addr(wx_ff, wy_ff);
            if (wx_ff == tx_ff && wy_ff == ty_ff) begin
               state_in = ST_F_WRITE;
            end else if (!in_map(wx_ff, wy_ff, width_ff, height_ff)) begin
               state_in = ST_NEXT;
            end else begin
               state_in = ST_F_SCHK;
            end
         end
         ST_F_SCHK: begin
            // registered data valid now
            if (rd_solid) begin
               state_in = ST_NEXT;
            end else begin
               state_in = ST_F_STEP;
            end
         end
         ST_F_WRITE: begin
            wr_addr = tile_addr(tx_ff, ty_ff);
            wr_solid = 1'b0;
            if (lv_raw > RW'(LEVEL_MAX)) begin
               wr_level = LEVEL_MAX;
            end else begin
               wr_level = LEVEL_W'(lv_raw);
            end
            if (wr_level < lvl_ff) begin
               wr_level = lvl_ff;
            end
            wr_en = 1'b1;
            state_in = ST_NEXT;
         end
         // ---- wall pass ----
         ST_W_TILE: begin
            addr_in = tile_addr(tx_ff, ty_ff);
            rd_addr = tile_addr(tx_ff, ty_ff);
            if (in_map(tx_ff, ty_ff, width_ff, height_ff)) begin
               state_in = ST_W_TWAIT;
            end else begin
               state_in = ST_NEXT;
            end
         end
         ST_W_TWAIT: state_in = ST_W_TCHK;
         ST_W_TCHK: begin
            best_in = '0;
            nb_in = '0;
            if (rd_solid && rd_level == '0) begin
               state_in = ST_W_NB;
            end else begin
               state_in = ST_NEXT;
            end
         end
         ST_W_NB: begin
            addr_in = tile_addr(nx, ny);
            rd_addr = tile_addr(nx, ny);
            if (in_map(nx, ny, width_ff, height_ff)) begin
               state_in = ST_W_NWAIT;
            end else begin
               state_in = (nb_ff == 3'd7) ? ST_W_WRITE : ST_W_NB;
               nb_in = nb_ff + 1'b1;
            end
         end
         ST_W_NWAIT: state_in = ST_W_NCHK;
         ST_W_NCHK: begin
            if (!rd_solid && rd_level > best_ff) begin
               best_in = rd_level;
            end
            nb_in = nb_ff + 1'b1;
            state_in = (nb_ff == 3'd7) ? ST_W_WRITE : ST_W_NB;
         end
         ST_W_WRITE: begin
            wr_addr = tile_addr(tx_ff, ty_ff);
            wr_solid = 1'b1;
            wr_level = best_ff;
            wr_en = (best_ff != '0);
            state_in = ST_NEXT;
         end
         ST_NEXT: begin
            // advance raster over the window
            if (tx_ff == px_ff + SW'(RADIUS)) begin
               tx_in = px_ff - SW'(RADIUS);
               ty_in = ty_ff + SW'(1);
               if (ty_ff == py_ff + SW'(RADIUS)) begin
                  state_in = ST_RESP;
               end
            end else begin
               tx_in = tx_ff + SW'(1);
            end
            if (state_in != ST_RESP) begin
               state_in = (cmd_ff == CMD_FLOOR) ? ST_F_TILE : ST_W_TILE;
            end
         end
         ST_RESP: begin
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp.rsp_valid = rsp_valid_ff;
   assign rsp.rsp_level = rsp_level_ff;
   assign rsp.rsp_solid_out = rsp_solid_ff;

   `GLM_ASSERT_SAME(a_ready_idle, clock, reset, req.req_ready, state_ff == ST_IDLE)
   `GLM_ASSERT_NEXT(a_resp_raise, clock, reset, state_ff == ST_RESP, rsp_valid_ff)
   `GLM_ASSERT_SAME(a_no_accept_busy, clock, reset, rsp_valid_ff, !req.req_ready)
endmodule
